// File: design/rcrc_pkg.sv
// ----------------------------------------------------------------------------
// rcrc_pkg
// Shared types, constants and tables for the circle versus rotated rectangle
// collision pipeline.
// ----------------------------------------------------------------------------
package rcrc_pkg;

    // coordinate bits that count, at most the 16-bit field width
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int FIELD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int ANG_W    = 34;             // theta, x, y, z in Q.30
    localparam int PROD_W   = FIELD_W + ANG_W; // coordinate times sine or cosine
    localparam int ROT_W    = PROD_W + 1;     // turned coordinate, Q.30
    localparam int DIST_W   = ROT_W + 1;      // distance outside the box
    localparam int HALF_W   = DIST_W / 2;     // split for the squaring
    localparam int PP_W     = 2 * HALF_W;
    localparam int SQ_W     = 2 * DIST_W + 1; // sum of two squares
    localparam int STEP_W   = 5;

    localparam logic signed [ANG_W-1:0] GAIN_Q30    = ANG_W'(34'h026DD3B6A);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(34'h06487ED51);
    localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(34'h0C90FDAA2);

    // operands of one item carried down the pipeline
    typedef struct packed {
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        logic [RADIUS_W-1:0]       radius;
    } pts_t;

    // state held by one rotator cell
    typedef struct packed {
        logic                    valid;
        logic                    flip;
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        pts_t                    pts;
    } cord_t;

    // turned points and radius between the rotate and box stages
    typedef struct packed {
        logic                    valid;
        logic signed [ROT_W-1:0] cx;
        logic signed [ROT_W-1:0] cy;
        logic signed [ROT_W-1:0] ax;
        logic signed [ROT_W-1:0] ay;
        logic signed [ROT_W-1:0] bx;
        logic signed [ROT_W-1:0] by;
        logic [RADIUS_W-1:0]     radius;
    } rot_t;

    // truncated atan(2^-i) in Q.30
    function automatic logic [ANG_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0:    r = ANG_W'(32'h3243F6A8);
            5'd1:    r = ANG_W'(32'h1DAC6705);
            5'd2:    r = ANG_W'(32'h0FADBAFC);
            5'd3:    r = ANG_W'(32'h07F56EA6);
            5'd4:    r = ANG_W'(32'h03FEAB76);
            5'd5:    r = ANG_W'(32'h01FFD55B);
            5'd6:    r = ANG_W'(32'h00FFFAAA);
            5'd7:    r = ANG_W'(32'h007FFF55);
            5'd8:    r = ANG_W'(32'h003FFFEA);
            5'd9:    r = ANG_W'(32'h001FFFFD);
            5'd10:   r = ANG_W'(32'h000FFFFF);
            5'd11:   r = ANG_W'(32'h0007FFFF);
            5'd12:   r = ANG_W'(32'h0003FFFF);
            5'd13:   r = ANG_W'(32'h0001FFFF);
            5'd14:   r = ANG_W'(32'h0000FFFF);
            5'd15:   r = ANG_W'(32'h00007FFF);
            5'd16:   r = ANG_W'(32'h00003FFF);
            5'd17:   r = ANG_W'(32'h00001FFF);
            5'd18:   r = ANG_W'(32'h00000FFF);
            5'd19:   r = ANG_W'(32'h000007FF);
            5'd20:   r = ANG_W'(32'h000003FF);
            5'd21:   r = ANG_W'(32'h000001FF);
            5'd22:   r = ANG_W'(32'h000000FF);
            5'd23:   r = ANG_W'(32'h0000007F);
            default: r = '0;
        endcase
        return r;
    endfunction

    // keep the low COORD_BITS bits of a coordinate, sign-extended
    function automatic logic signed [FIELD_W-1:0] coord_sext(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = $signed(v << (FIELD_W - COORD_BITS));
        return t >>> (FIELD_W - COORD_BITS);
    endfunction

endpackage

// File: design/rcrc_cordic_cell.sv
// ----------------------------------------------------------------------------
// rcrc_cordic_cell
// One rotation step of the sine/cosine chain; passes the item operands along.
// ----------------------------------------------------------------------------
module rcrc_cordic_cell
    import rcrc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  cord_t             cell_in,
    output cord_t             cell_out
);

    cord_t cell_reg;
    cord_t cell_next;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic signed [ANG_W-1:0] at;

    // micro-rotation toward z = 0
    always_comb begin
        xs        = cell_in.x >>> step;
        ys        = cell_in.y >>> step;
        at        = $signed(atan_q30(step));
        cell_next = cell_in;
        if (!cell_in.z[ANG_W-1]) begin
            cell_next.x = cell_in.x - ys;
            cell_next.y = cell_in.y + xs;
            cell_next.z = cell_in.z - at;
        end else begin
            cell_next.x = cell_in.x + ys;
            cell_next.y = cell_in.y - xs;
            cell_next.z = cell_in.z + at;
        end
    end

    // step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: design/rcrc_rotate.sv
// ----------------------------------------------------------------------------
// rcrc_rotate
// Turns the center and both corners by the CORDIC sine and cosine: products
// are registered, then combined into exact Q.30 coordinates.
// ----------------------------------------------------------------------------
module rcrc_rotate
    import rcrc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cord_t rot_in,
    output rot_t  rot_out
);

    logic signed [ANG_W-1:0] c;
    logic signed [ANG_W-1:0] s;
    logic signed [PROD_W-1:0] pc_next [6];
    logic signed [PROD_W-1:0] ps_next [6];
    logic signed [PROD_W-1:0] pc_reg  [6];
    logic signed [PROD_W-1:0] ps_reg  [6];
    logic signed [FIELD_W-1:0] p [6];
    logic                  prod_valid_reg;
    logic [RADIUS_W-1:0]   prod_radius_reg;
    rot_t                  rot_reg;
    rot_t                  rot_next;

    // undo the half-turn reduction
    assign c = rot_in.flip ? -rot_in.x : rot_in.x;
    assign s = rot_in.flip ? -rot_in.y : rot_in.y;

    assign p[0] = rot_in.pts.cx;
    assign p[1] = rot_in.pts.cy;
    assign p[2] = rot_in.pts.ax;
    assign p[3] = rot_in.pts.ay;
    assign p[4] = rot_in.pts.bx;
    assign p[5] = rot_in.pts.by;

    // one product pair per coordinate
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            pc_next[k] = p[k] * c;
            ps_next[k] = p[k] * s;
        end
    end

    // product registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= rot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg          <= pc_next;
            ps_reg          <= ps_next;
            prod_radius_reg <= rot_in.pts.radius;
        end
    end

    // x' = x cos - y sin, y' = x sin + y cos
    always_comb begin
        rot_next.valid  = prod_valid_reg;
        rot_next.radius = prod_radius_reg;
        rot_next.cx = ROT_W'(pc_reg[0]) - ROT_W'(ps_reg[1]);
        rot_next.cy = ROT_W'(ps_reg[0]) + ROT_W'(pc_reg[1]);
        rot_next.ax = ROT_W'(pc_reg[2]) - ROT_W'(ps_reg[3]);
        rot_next.ay = ROT_W'(ps_reg[2]) + ROT_W'(pc_reg[3]);
        rot_next.bx = ROT_W'(pc_reg[4]) - ROT_W'(ps_reg[5]);
        rot_next.by = ROT_W'(ps_reg[4]) + ROT_W'(pc_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg.valid <= 1'b0;
        end else if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_out = rot_reg;

endmodule

// File: design/rcrc_box.sv
// ----------------------------------------------------------------------------
// rcrc_box
// Distance of the turned center outside the axis-aligned box, squared in
// halves, summed and compared with the radius squared.
// ----------------------------------------------------------------------------
module rcrc_box
    import rcrc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  rot_t box_in,
    output logic box_valid,
    output logic box_hit
);

    logic [DIST_W-1:0]   dx_next;
    logic [DIST_W-1:0]   dy_next;
    logic [DIST_W-1:0]   dx_reg;
    logic [DIST_W-1:0]   dy_reg;
    logic                dist_valid_reg;
    logic [RADIUS_W-1:0] dist_radius_reg;
    logic [PP_W-1:0]     pp_next [6];
    logic [PP_W-1:0]     pp_reg  [6];
    logic                pp_valid_reg;
    logic [2*RADIUS_W-1:0] r2_next;
    logic [2*RADIUS_W-1:0] r2_reg;
    logic [SQ_W-1:0]     sum;
    logic [SQ_W-1:0]     r2_full;

    // distance of c outside the interval spanned by a and b
    function automatic logic [DIST_W-1:0] outside(input logic signed [ROT_W-1:0] c,
                                                 input logic signed [ROT_W-1:0] a,
                                                 input logic signed [ROT_W-1:0] b);
        logic signed [ROT_W-1:0] lo;
        logic signed [ROT_W-1:0] hi;
        logic [DIST_W-1:0] d;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) begin
            d = DIST_W'($signed({lo[ROT_W-1], lo}) - $signed({c[ROT_W-1], c}));
        end else if (hi < c) begin
            d = DIST_W'($signed({c[ROT_W-1], c}) - $signed({hi[ROT_W-1], hi}));
        end else begin
            d = '0;
        end
        return d;
    endfunction

    assign dx_next = outside(box_in.cx, box_in.ax, box_in.bx);
    assign dy_next = outside(box_in.cy, box_in.ay, box_in.by);

    // distance registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_valid_reg <= 1'b0;
            pp_valid_reg   <= 1'b0;
        end else if (en) begin
            dist_valid_reg <= box_in.valid;
            pp_valid_reg   <= dist_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg          <= dx_next;
            dy_reg          <= dy_next;
            dist_radius_reg <= box_in.radius;
            pp_reg          <= pp_next;
            r2_reg          <= r2_next;
        end
    end

    // partial products of the squares
    always_comb begin
        pp_next[0] = PP_W'(dx_reg[DIST_W-1:HALF_W]) * PP_W'(dx_reg[DIST_W-1:HALF_W]);
        pp_next[1] = PP_W'(dx_reg[DIST_W-1:HALF_W]) * PP_W'(dx_reg[HALF_W-1:0]);
        pp_next[2] = PP_W'(dx_reg[HALF_W-1:0]) * PP_W'(dx_reg[HALF_W-1:0]);
        pp_next[3] = PP_W'(dy_reg[DIST_W-1:HALF_W]) * PP_W'(dy_reg[DIST_W-1:HALF_W]);
        pp_next[4] = PP_W'(dy_reg[DIST_W-1:HALF_W]) * PP_W'(dy_reg[HALF_W-1:0]);
        pp_next[5] = PP_W'(dy_reg[HALF_W-1:0]) * PP_W'(dy_reg[HALF_W-1:0]);
        r2_next    = (2*RADIUS_W)'(dist_radius_reg) * (2*RADIUS_W)'(dist_radius_reg);
    end

    // sum of squares against radius squared (radius taken to Q.30)
    always_comb begin
        sum = (SQ_W'(pp_reg[0]) << (2*HALF_W)) + (SQ_W'(pp_reg[1]) << (HALF_W+1))
            + SQ_W'(pp_reg[2])
            + (SQ_W'(pp_reg[3]) << (2*HALF_W)) + (SQ_W'(pp_reg[4]) << (HALF_W+1))
            + SQ_W'(pp_reg[5]);
        r2_full = SQ_W'(r2_reg) << 60;
    end

    assign box_valid = pp_valid_reg;
    assign box_hit   = (sum < r2_full);

endmodule

// File: design/rotated_circle_rect_collision_top.sv
// ----------------------------------------------------------------------------
// rotated_circle_rect_collision_top
// Circle versus rotated rectangle collision test, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel s_*: one item holds the angle, circle center and radius and
// two opposite rectangle corners. Result channel m_*: one item per input
// item, m_hit set when the circle overlaps the rectangle.
// Stages: one angle-reduction stage, one cell per CORDIC step, two rotation
// stages, two box stages and the output register.
// Throughput: one item per cycle while the output is not stalled; every
// stage is its own register, so a new item enters while earlier ones are
// still in the chain.
// Stall: all stages advance together when the output register is empty or
// taken; while m_valid is high and m_ready low the pipeline holds and
// s_ready is low. Empty stages hold as well, so gaps in the chain are not
// closed up during a stall.
// Reset: aresetn clears all valid bits; the block takes items as soon as
// reset is released.
// ----------------------------------------------------------------------------
module rotated_circle_rect_collision_top
    import rcrc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_angle,
    input  logic signed [FIELD_W-1:0] s_center_x,
    input  logic signed [FIELD_W-1:0] s_center_y,
    input  logic [RADIUS_W-1:0]       s_radius,
    input  logic signed [FIELD_W-1:0] s_corner_a_x,
    input  logic signed [FIELD_W-1:0] s_corner_a_y,
    input  logic signed [FIELD_W-1:0] s_corner_b_x,
    input  logic signed [FIELD_W-1:0] s_corner_b_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit
);

    logic              en;
    cord_t             prep_reg;
    cord_t             prep_next;
    cord_t             chain [CORDIC_STEPS+1];
    rot_t              rot;
    logic              box_valid;
    logic              box_hit;
    logic              m_valid_reg;
    logic              m_hit_reg;
    logic signed [ANG_W-1:0] theta;

    // whole pipeline moves when the output slot frees up
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // theta = -angle in Q.30, folded into -pi/2..pi/2
    always_comb begin
        theta          = -(ANG_W'(s_angle) <<< 17);
        prep_next.valid = s_valid;
        prep_next.flip  = 1'b0;
        prep_next.x     = GAIN_Q30;
        prep_next.y     = '0;
        prep_next.z     = theta;
        if (theta > HALF_PI_Q30) begin
            prep_next.z    = theta - PI_Q30;
            prep_next.flip = 1'b1;
        end else if (theta < -HALF_PI_Q30) begin
            prep_next.z    = theta + PI_Q30;
            prep_next.flip = 1'b1;
        end
        prep_next.pts.cx     = coord_sext(s_center_x);
        prep_next.pts.cy     = coord_sext(s_center_y);
        prep_next.pts.ax     = coord_sext(s_corner_a_x);
        prep_next.pts.ay     = coord_sext(s_corner_a_y);
        prep_next.pts.bx     = coord_sext(s_corner_b_x);
        prep_next.pts.by     = coord_sext(s_corner_b_y);
        prep_next.pts.radius = s_radius;
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg.valid <= 1'b0;
        end else if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign chain[0] = prep_reg;

    // chain of CORDIC cells
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rcrc_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step     (STEP_W'(g)),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    rcrc_rotate u_rotate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rot_in  (chain[CORDIC_STEPS]),
        .rot_out (rot)
    );

    rcrc_box u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .box_in    (rot),
        .box_valid (box_valid),
        .box_hit   (box_hit)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= box_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= box_hit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

endmodule

// File: design/rcrc_checker.sv
// ----------------------------------------------------------------------------
// rcrc_checker
// Port-level checks of the collision pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rcrc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    // no result item right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output slot always lets an item in
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a stalled result blocks the input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    // stalled result holds its value
    a_hit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hit)))
        else $error("stalled result changed");

endmodule

bind rotated_circle_rect_collision_top rcrc_checker u_rcrc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the circle versus rotated rectangle collision pipeline: a directed
// table followed by random items, each predicted by a local CORDIC rotation
// and exact box distance test, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rcrc_pkg::*;

    localparam int N_RANDOM = 630;
    localparam int MAX_IDLE = 10;

    // fields of one input item
    typedef struct {
        logic signed [FIELD_W-1:0] ang;
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic [RADIUS_W-1:0]       rad;
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by;
        int                        known; // -1 when the predictor decides
    } probe_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [FIELD_W-1:0] s_angle;
    logic signed [FIELD_W-1:0] s_center_x;
    logic signed [FIELD_W-1:0] s_center_y;
    logic [RADIUS_W-1:0]       s_radius;
    logic signed [FIELD_W-1:0] s_corner_a_x;
    logic signed [FIELD_W-1:0] s_corner_a_y;
    logic signed [FIELD_W-1:0] s_corner_b_x;
    logic signed [FIELD_W-1:0] s_corner_b_y;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_hit;

    logic hit_queue[$];
    int   mismatches;
    bit   feeding_done;

    rotated_circle_rect_collision_top dut (.*);

    // clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // own atan table, truncated Q.30
    function automatic longint atan_step(input int i);
        longint t[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return t[i];
    endfunction

    // low COORD_BITS bits, sign-extended
    function automatic longint trim_coord(input logic [FIELD_W-1:0] v);
        longint r;
        r = longint'(v[COORD_BITS-1:0]);
        if (v[COORD_BITS-1])
            r = r - (longint'(1) << COORD_BITS);
        return r;
    endfunction

    // distance of c outside the span of a and b
    function automatic logic signed [127:0] gap(input logic signed [127:0] c,
            input logic signed [127:0] a, input logic signed [127:0] b);
        logic signed [127:0] lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo)
            return lo - c;
        if (hi < c)
            return c - hi;
        return 0;
    endfunction

    // predicted overlap of circle and turned rectangle
    function automatic logic predict_hit(input probe_t p);
        longint theta, x, y, z, xs, ys, c, s;
        longint px[3], py[3];
        logic signed [127:0] rx[3], ry[3], dx, dy, sum, rq;
        bit flip;
        theta = -longint'(p.ang) * 131072;
        flip = 0;
        if (theta > 64'sh6487ED51) begin
            theta -= 64'shC90FDAA2;
            flip = 1;
        end else if (theta < -64'sh6487ED51) begin
            theta += 64'shC90FDAA2;
            flip = 1;
        end
        x = 64'h26DD3B6A;
        y = 0;
        z = theta;
        // rotation steps with arithmetic shifts
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_step(i);
            end else begin
                x += ys;
                y -= xs;
                z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        px[0] = trim_coord(p.cx);
        py[0] = trim_coord(p.cy);
        px[1] = trim_coord(p.ax);
        py[1] = trim_coord(p.ay);
        px[2] = trim_coord(p.bx);
        py[2] = trim_coord(p.by);
        for (int i = 0; i < 3; i++) begin
            rx[i] = 128'(px[i]) * 128'(c) - 128'(py[i]) * 128'(s);
            ry[i] = 128'(px[i]) * 128'(s) + 128'(py[i]) * 128'(c);
        end
        dx = gap(rx[0], rx[1], rx[2]);
        dy = gap(ry[0], ry[1], ry[2]);
        sum = dx * dx + dy * dy;
        rq = 128'(p.rad) << 30;
        return (sum < rq * rq);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // drive one item and record its expected hit
    task automatic send_item(input probe_t p);
        int idle;
        idle = $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 3) == 0)
            idle = 0;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_angle      <= p.ang;
        s_center_x   <= p.cx;
        s_center_y   <= p.cy;
        s_radius     <= p.rad;
        s_corner_a_x <= p.ax;
        s_corner_a_y <= p.ay;
        s_corner_b_x <= p.bx;
        s_corner_b_y <= p.by;
        s_valid      <= 1'b1;
        if (p.known >= 0 && p.known != int'(predict_hit(p)))
            report_mismatch("predictor disagrees with directed row");
        hit_queue.push_back(p.known >= 0 ? p.known[0] : predict_hit(p));
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic probe_t pick_random();
        probe_t p;
        int w;
        p.ang = FIELD_W'($urandom_range(0, 3) == 0 ? $urandom
                : $signed($urandom_range(0, 51472)) - 25736);
        p.rad = RADIUS_W'($urandom);
        w = 1 << $urandom_range(4, 15);
        // mostly nearby geometry so hits and misses both occur
        p.cx = FIELD_W'($urandom_range(0, 2 * w) - w);
        p.cy = FIELD_W'($urandom_range(0, 2 * w) - w);
        p.ax = FIELD_W'($urandom_range(0, 2 * w) - w);
        p.ay = FIELD_W'($urandom_range(0, 2 * w) - w);
        p.bx = FIELD_W'($urandom_range(0, 2 * w) - w);
        p.by = FIELD_W'($urandom_range(0, 2 * w) - w);
        if ($urandom_range(0, 9) == 0) begin
            p.cx = FIELD_W'($urandom);
            p.ax = FIELD_W'($urandom);
            p.by = FIELD_W'($urandom);
        end
        if (w > 256)
            p.rad = RADIUS_W'($urandom_range(0, w));
        else
            p.rad = RADIUS_W'($urandom_range(0, 4 * w));
        p.known = -1;
        return p;
    endfunction

    // stimulus
    initial begin
        probe_t rows[$];
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_angle      = '0;
        s_center_x   = '0;
        s_center_y   = '0;
        s_radius     = '0;
        s_corner_a_x = '0;
        s_corner_a_y = '0;
        s_corner_b_x = '0;
        s_corner_b_y = '0;
        mismatches   = 0;
        feeding_done = 0;
        // ang, cx, cy, rad, ax, ay, bx, by, known hit
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 15'd16, -16'sd16, -16'sd16,
                         16'sd16, 16'sd16, 1});
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 15'd0, -16'sd16, -16'sd16,
                         16'sd16, 16'sd16, 0});
        rows.push_back('{16'sd0, 16'sd1000, 16'sd0, 15'd10, -16'sd16, -16'sd16,
                         16'sd16, 16'sd16, 0});
        rows.push_back('{16'sd0, 16'sd100, 16'sd0, 15'd200, 16'sd16, 16'sd16,
                         -16'sd16, -16'sd16, 1});
        rows.push_back('{16'sd25736, 16'sd0, 16'sd0, 15'd1, -16'sd80, -16'sd80,
                         16'sd80, 16'sd80, 1});
        rows.push_back('{-16'sd25736, 16'sd300, 16'sd0, 15'd20, -16'sd80,
                         -16'sd80, 16'sd80, 16'sd80, -1});
        rows.push_back('{16'sh7FFF, 16'sd40, 16'sd40, 15'd30, 16'sd0, 16'sd0,
                         16'sd100, 16'sd30, -1});
        rows.push_back('{-16'sh8000, 16'sd40, -16'sd40, 15'd30, 16'sd0, 16'sd0,
                         16'sd100, 16'sd30, -1});
        rows.push_back('{16'sd12868, 16'sd50, 16'sd0, 15'd10, -16'sd100,
                         16'sd0, 16'sd100, 16'sd0, -1});
        rows.push_back('{-16'sd12868, 16'sd0, 16'sd0, 15'd1, 16'sd5, 16'sd5,
                         16'sd5, 16'sd5, -1});
        rows.push_back('{16'sd6434, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, -16'sh8000,
                         -16'sh8000, 16'sh7FFF, 16'sh7FFF, 1});
        rows.push_back('{16'sd3000, -16'sh8000, 16'sh7FFF, 15'h7FFF,
                         16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -1});
        rows.push_back('{16'sd0, 16'sh7FFF, -16'sh8000, 15'h7FFF, 16'sd0,
                         16'sd0, 16'sd0, 16'sd0, -1});
        rows.push_back('{16'sd20000, 16'sd500, 16'sd500, 15'd100, 16'sd400,
                         16'sd600, 16'sd450, 16'sd700, -1});
        rows.push_back('{-16'sd1, 16'sd0, 16'sd0, 15'h5555, 16'shAAAA,
                         16'sh5555, 16'sh5555, 16'shAAAA, -1});
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        foreach (rows[i])
            send_item(rows[i]);
        repeat (N_RANDOM)
            send_item(pick_random());
        s_valid <= 1'b0;
        feeding_done = 1;
    end

    // result side: random stalls and checks
    initial begin
        int idle;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_IDLE);
            @(negedge aclk);
            if (idle > 0) begin
                m_ready <= 1'b0;
                repeat (idle) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            if (hit_queue.size() == 0)
                report_mismatch("result with nothing expected");
            else if (m_hit !== hit_queue.pop_front())
                report_mismatch($sformatf("hit %b wrong", m_hit));
        end
    end

    // end of run
    initial begin
        wait (feeding_done);
        while (hit_queue.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
